// ===== src/lidar_tilt_gaze_controller_assert.svh =====
// Assertion macros for the gaze controller.
`ifndef LIDAR_TILT_GAZE_CONTROLLER_ASSERT_SVH
`define LIDAR_TILT_GAZE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define LTGC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LTGC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ltgc_pkg.sv =====
package ltgc_pkg;

  localparam int AngleW = 16;
  localparam int RangeW = 16;
  localparam int ErrW   = 17;
  localparam int StepW  = 10;
  localparam int KindW  = 3;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  typedef logic signed [AngleW-1:0] angle_t;
  typedef logic [RangeW-1:0]        range_t;
  typedef logic [ErrW-1:0]          err_t;
  typedef logic [KindW-1:0]         kind_t;
  typedef logic [1:0]               speed_t;

  // Item kinds
  localparam kind_t KIND_SCAN  = 3'd0;
  localparam kind_t KIND_TICK  = 3'd1;
  localparam kind_t KIND_REPLY = 3'd2;
  localparam kind_t KIND_SWEEP = 3'd3;
  localparam kind_t KIND_GOAL  = 3'd4;

  // Speed codes
  localparam speed_t SPEED_STOP  = 2'd0;
  localparam speed_t SPEED_SWEEP = 2'd1;
  localparam speed_t SPEED_FULL  = 2'd2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_UP_REVERSED     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_UP_LIMIT        = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DOWN_LIMIT      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_UP_SAFE_LIMIT   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RANGE_TOLERANCE = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SLOW_STEP       = 3'd5;

  // Q1.14 angles, 1/256 m ranges
  localparam logic [ErrW-1:0]     POS_TOL    = 17'd29;   // 0.1 deg
  localparam logic signed [16:0]  NOD_STEP   = 17'sd2860; // 10 deg
  localparam logic signed [16:0]  CREEP_STEP = 17'sd57;   // 0.2 deg
  localparam angle_t              INIT_TILT  = 16'sd1430; // 5 deg
  localparam range_t              INIT_GOAL  = 16'd1280;  // 5 m
  localparam err_t                ERR_MARKER = '1;

  localparam angle_t RST_UP_LIMIT      = 16'sd0;
  localparam angle_t RST_DOWN_LIMIT    = -16'sd8192;
  localparam angle_t RST_UP_SAFE_LIMIT = -16'sd2048;
  localparam range_t RST_RANGE_TOL     = 16'd128;
  localparam logic [StepW-1:0] RST_SLOW_STEP = 10'd57;

  typedef enum logic [3:0] {
    MODE_TRACK = 4'b0001,
    MODE_START = 4'b0010,
    MODE_SWEEP = 4'b0100,
    MODE_END   = 4'b1000
  } mode_t;

  // |a - b| of two 16-bit signed angles
  function automatic err_t angle_dist(angle_t a, angle_t b);
    logic signed [16:0] d;
    d = 17'(a) - 17'(b);
    return d[16] ? err_t'(-d) : err_t'(d);
  endfunction

  // Tilt lies between the given upper bound and the down limit
  function automatic logic tilt_within(logic rev, angle_t t, angle_t upper, angle_t lower);
    if (!rev) begin
      return (t <= upper) && (t >= lower);
    end
    return (t >= upper) && (t <= lower);
  endfunction

endpackage

// ===== src/ltgc_in_if.sv =====
interface ltgc_in_if;
  import ltgc_pkg::*;

  logic   valid;
  logic   ready;
  kind_t  kind;
  angle_t tilt_angle;
  range_t avg_range;
  logic   bad_scan;
  range_t goal_range;

  modport source (output valid, kind, tilt_angle, avg_range, bad_scan, goal_range,
                  input ready);
  modport sink   (input valid, kind, tilt_angle, avg_range, bad_scan, goal_range,
                  output ready);
endinterface

// ===== src/ltgc_out_if.sv =====
interface ltgc_out_if;
  import ltgc_pkg::*;

  logic   valid;
  logic   ready;
  logic   use_line;
  logic   command_valid;
  angle_t tilt_target;
  speed_t speed_code;
  logic   is_tracking;
  logic   is_sweeping;

  modport source (output valid, use_line, command_valid, tilt_target, speed_code,
                  is_tracking, is_sweeping, input ready);
  modport sink   (input valid, use_line, command_valid, tilt_target, speed_code,
                  is_tracking, is_sweeping, output ready);
endinterface

// ===== src/lidar_tilt_gaze_controller.sv =====
// Tilt gaze controller for a scanning range sensor.
// Channels: item (sink) carries scan reports, cycle ticks, tilt replies, sweep
// requests and range goals; result (source) returns exactly one beat per item
// with the scan verdict, the tilt command for ticks and the mode flags.
// Both use valid/ready; a beat moves when both are high.
// Configuration: cfg_wen/cfg_index/cfg_data write one register per cycle,
// indexes above 5 are dropped. Write only while no item is in flight.
// Path: an item lands in the input register, then the mode update and the
// result are computed in one pass and loaded into the result register, from
// which the result is offered on the result channel.
// Throughput: one item per cycle while result.ready is high, set by the single
// compare/clamp pass between the input and result registers.
// Reset (rst, synchronous): tracking mode, not started, target tilt 5 deg,
// range goal 5 m, configuration at its defaults, both registers empty.
// Stall: while result.ready is low the held result stays put, one more item
// may sit in the input register, and then item.ready drops.
module lidar_tilt_gaze_controller (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [ltgc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ltgc_pkg::CfgDataW-1:0] cfg_data,
  ltgc_in_if.sink                       item,
  ltgc_out_if.source                    result
);
  import ltgc_pkg::*;

  // configuration
  logic             up_reversed;
  angle_t           up_limit;
  angle_t           down_limit;
  angle_t           up_safe_limit;
  range_t           range_tolerance;
  logic [StepW-1:0] slow_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      up_reversed     <= 1'b0;
      up_limit        <= RST_UP_LIMIT;
      down_limit      <= RST_DOWN_LIMIT;
      up_safe_limit   <= RST_UP_SAFE_LIMIT;
      range_tolerance <= RST_RANGE_TOL;
      slow_step       <= RST_SLOW_STEP;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_UP_REVERSED:     up_reversed     <= cfg_data[0];
        REG_UP_LIMIT:        up_limit        <= angle_t'(cfg_data);
        REG_DOWN_LIMIT:      down_limit      <= angle_t'(cfg_data);
        REG_UP_SAFE_LIMIT:   up_safe_limit   <= angle_t'(cfg_data);
        REG_RANGE_TOLERANCE: range_tolerance <= cfg_data;
        REG_SLOW_STEP:       slow_step       <= cfg_data[StepW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic   s0_valid;
  kind_t  s0_kind;
  angle_t s0_tilt;
  range_t s0_range;
  logic   s0_bad;
  range_t s0_goal;

  logic out_valid;
  logic advance;

  assign advance    = !out_valid || result.ready;
  assign item.ready = !s0_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (item.ready) begin
      s0_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      s0_kind  <= item.kind;
      s0_tilt  <= item.tilt_angle;
      s0_range <= item.avg_range;
      s0_bad   <= item.bad_scan;
      s0_goal  <= item.goal_range;
    end
  end

  // controller state
  mode_t  mode, mode_next;
  logic   started, started_next;
  angle_t last_tilt, last_tilt_next;
  angle_t next_tilt, next_tilt_next;
  range_t range_goal, range_goal_next;
  err_t   best_error, best_error_next;
  angle_t best_tilt, best_tilt_next;

  logic   fire;
  assign fire = s0_valid && advance;

  // scan report arithmetic
  logic               scan_ok;
  err_t               goal_dist;
  err_t               scan_err;
  logic signed [17:0] goal_hi, goal_lo, range_ext;
  logic               too_far, too_near;
  logic signed [16:0] nt_raw;
  angle_t             clamp_lo, clamp_hi, nt;

  assign scan_ok   = tilt_within(up_reversed, s0_tilt, up_limit, down_limit);
  assign goal_dist = (s0_range >= range_goal) ? err_t'(s0_range - range_goal)
                                              : err_t'(range_goal - s0_range);
  assign scan_err  = goal_dist;
  assign range_ext = {2'b00, s0_range};
  assign goal_hi   = {2'b00, range_goal} + {2'b00, range_tolerance};
  assign goal_lo   = {2'b00, range_goal} - {2'b00, range_tolerance};
  assign too_far   = range_ext > goal_hi;
  assign too_near  = range_ext < goal_lo;

  always_comb begin
    priority if (s0_bad) begin
      nt_raw = up_reversed ? 17'(s0_tilt) + NOD_STEP : 17'(s0_tilt) - NOD_STEP;
    end else if (too_far) begin
      nt_raw = up_reversed ? 17'(s0_tilt) + $signed({7'b0, slow_step})
                           : 17'(s0_tilt) - $signed({7'b0, slow_step});
    end else if (too_near) begin
      nt_raw = up_reversed ? 17'(s0_tilt) - CREEP_STEP : 17'(s0_tilt) + CREEP_STEP;
    end else begin
      nt_raw = 17'(last_tilt);
    end
  end

  assign clamp_lo = (down_limit < up_safe_limit) ? down_limit : up_safe_limit;
  assign clamp_hi = (down_limit < up_safe_limit) ? up_safe_limit : down_limit;

  always_comb begin
    priority if (nt_raw < 17'(clamp_lo)) begin
      nt = clamp_lo;
    end else if (nt_raw > 17'(clamp_hi)) begin
      nt = clamp_hi;
    end else begin
      nt = angle_t'(nt_raw);
    end
  end

  // one pass over the held item
  logic   res_use, res_cmd;
  angle_t res_pos;
  speed_t res_speed;
  logic   adjust;

  assign adjust = s0_bad || (goal_dist >= {1'b0, range_tolerance}) || !scan_ok;

  always_comb begin
    mode_next       = mode;
    started_next    = started;
    last_tilt_next  = last_tilt;
    next_tilt_next  = next_tilt;
    range_goal_next = range_goal;
    best_error_next = best_error;
    best_tilt_next  = best_tilt;
    res_use         = 1'b0;
    res_cmd         = 1'b0;
    res_pos         = '0;
    res_speed       = SPEED_STOP;

    unique case (s0_kind)
      KIND_SCAN: begin
        started_next = 1'b1;
        res_use      = !s0_bad && scan_ok;
        if (adjust) begin
          if (mode == MODE_SWEEP && !s0_bad && scan_err < best_error) begin
            best_error_next = scan_err;
            best_tilt_next  = s0_tilt;
          end
          if (mode == MODE_TRACK && angle_dist(last_tilt, nt) > POS_TOL) begin
            next_tilt_next = nt;
          end
        end
      end
      KIND_TICK: begin
        if (started) begin
          res_cmd   = 1'b1;
          res_speed = SPEED_FULL;
          unique case (mode)
            MODE_START: begin
              if (angle_dist(last_tilt, down_limit) < POS_TOL) begin
                mode_next       = MODE_SWEEP;
                res_pos         = up_limit;
                res_speed       = SPEED_SWEEP;
                best_tilt_next  = up_limit;
                best_error_next = ERR_MARKER;
              end else begin
                res_pos = down_limit;
              end
            end
            MODE_SWEEP: begin
              if (angle_dist(last_tilt, up_limit) < POS_TOL) begin
                mode_next = MODE_END;
                res_pos   = best_tilt;
              end else begin
                res_pos   = up_limit;
                res_speed = SPEED_SWEEP;
              end
            end
            MODE_END: begin
              if (angle_dist(last_tilt, best_tilt) < POS_TOL) begin
                mode_next      = MODE_TRACK;
                res_pos        = last_tilt;
                res_speed      = SPEED_STOP;
                next_tilt_next = last_tilt;
              end else begin
                res_pos = best_tilt;
              end
            end
            default: res_pos = next_tilt;
          endcase
        end
      end
      KIND_REPLY: last_tilt_next = s0_tilt;
      KIND_SWEEP: begin
        if (mode == MODE_TRACK) begin
          mode_next = MODE_START;
        end
      end
      KIND_GOAL: range_goal_next = s0_goal;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_TRACK;
      started    <= 1'b0;
      last_tilt  <= '0;
      next_tilt  <= INIT_TILT;
      range_goal <= INIT_GOAL;
      best_error <= '0;
      best_tilt  <= '0;
    end else if (fire) begin
      mode       <= mode_next;
      started    <= started_next;
      last_tilt  <= last_tilt_next;
      next_tilt  <= next_tilt_next;
      range_goal <= range_goal_next;
      best_error <= best_error_next;
      best_tilt  <= best_tilt_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.use_line      <= res_use;
      result.command_valid <= res_cmd;
      result.tilt_target   <= res_pos;
      result.speed_code    <= res_speed;
      result.is_tracking   <= started_next && mode_next == MODE_TRACK &&
                              tilt_within(up_reversed, last_tilt_next, up_safe_limit,
                                          down_limit);
      result.is_sweeping   <= started_next && mode_next == MODE_SWEEP;
    end
  end

  assign result.valid = out_valid;

`include "lidar_tilt_gaze_controller_assert.svh"

  `LTGC_ASSERT_NEXT(a_fire_gives_beat, clk, rst, fire, result.valid,
                    "processed item did not reach the result register")
  `LTGC_ASSERT_NOW(a_cmd_needs_start, clk, rst, result.valid && result.command_valid,
                   started, "tilt command issued before first scan report")
  `LTGC_ASSERT_NOW(a_flags_exclusive, clk, rst, result.valid,
                   !(result.is_tracking && result.is_sweeping),
                   "tracking and sweeping flagged together")
  `LTGC_ASSERT_NOW(a_idle_cmd_zero, clk, rst, result.valid && !result.command_valid,
                   result.tilt_target == '0 && result.speed_code == SPEED_STOP,
                   "command fields set without a command")

endmodule
